>>> hdl/bidirectional_flow_stats_table_core_defines.svh
// ----------------------------------------------------------------------------
// Flow table assertion macros
// Shared property forms for the flow statistics table checks.
// ----------------------------------------------------------------------------
`ifndef BIDIRECTIONAL_FLOW_STATS_TABLE_CORE_DEFINES_SVH
`define BIDIRECTIONAL_FLOW_STATS_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define BFST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bfst_pkg.sv
// ----------------------------------------------------------------------------
// Flow table package
// Sizes, codes and record types of the flow statistics table.
// ----------------------------------------------------------------------------
package bfst_pkg;

	localparam int FLOW_SETS = 256;
	localparam int FLOW_WAYS = 4;
	localparam int SET_W = (FLOW_SETS > 1) ? $clog2(FLOW_SETS) : 1;
	localparam int WAY_W = (FLOW_WAYS > 1) ? $clog2(FLOW_WAYS) : 1;
	localparam int SLOT_W = 10;

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam int FLAG_FIN_BIT = 0;
	localparam int FLAG_SYN_BIT = 1;

	localparam logic [1:0] OUT_IGNORED = 2'd0;
	localparam logic [1:0] OUT_UPDATED = 2'd1;
	localparam logic [1:0] OUT_INSERTED = 2'd2;
	localparam logic [1:0] OUT_FULL = 2'd3;

	localparam logic [1:0] CS_SYN = 2'd0;
	localparam logic [1:0] CS_ESTAB = 2'd1;
	localparam logic [1:0] CS_FIN = 2'd2;
	localparam logic [1:0] CS_UDP = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	typedef struct packed {
		logic [63:0] kaddr;
		logic [39:0] kports;
		logic [63:0] first;
		logic [31:0] pkts;
		logic [31:0] bytes;
		logic [31:0] fpkts;
		logic [31:0] fbytes;
		logic [15:0] longest;
		logic [15:0] win;
		logic [1:0]  cstate;
	} rec_t;

	typedef struct packed {
		logic [FLOW_WAYS-1:0] vld;
		rec_t [FLOW_WAYS-1:0] rec;
	} row_t;

endpackage

>>> hdl/bidirectional_flow_stats_table_core.sv
// ----------------------------------------------------------------------------
// Bidirectional flow statistics table
// Canonical five-tuple lookup, insert and per-flow counter update.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries the header fields of one frame;
// output channel out_valid/out_ready returns one result per request.
// A request is accepted only in idle; the set row is read from the table
// memory in the accept cycle. In the lookup state, once the output register
// is free or being taken, all ways are compared, the updated row is written
// back and the output register is loaded. The block takes no new request
// until that read-modify-write of the single set row is done.
// A finished result waits in the output register; while it is not taken the
// next request is still accepted, and its lookup holds until the register
// frees. After reset a clearing pass writes each of the FLOW_SETS (256) set
// rows to empty, one row per cycle, during which in_ready stays low.
// Ignored frames and table-full requests return zeroed fields with their
// outcome code and leave the table unchanged.
// ----------------------------------------------------------------------------
`include "bidirectional_flow_stats_table_core_defines.svh"

module bidirectional_flow_stats_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] ether_type,
	input  logic [7:0]  ip_protocol,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [7:0]  tcp_flag_bits,
	input  logic [15:0] tcp_window,
	input  logic [15:0] packet_length,
	input  logic [63:0] arrival_time,
	input  logic        headers_complete,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  outcome,
	output logic [bfst_pkg::SLOT_W-1:0] slot,
	output logic        forward_dir,
	output logic [31:0] flow_packets,
	output logic [31:0] flow_bytes,
	output logic [31:0] forward_packets,
	output logic [31:0] forward_bytes,
	output logic [15:0] longest_forward,
	output logic [15:0] syn_window,
	output logic [1:0]  conn_state,
	output logic [63:0] flow_start
);
	import bfst_pkg::*;

	state_t state_q, state_d;
	logic [SET_W-1:0] clr_q;
	logic in_acc, lookup_done, clearing;

	row_t mem [FLOW_SETS];
	row_t rd_row_q, wr_row;
	logic mem_we;
	logic [SET_W-1:0] mem_waddr;

	// canonical tuple at accept
	logic swapped;
	logic [31:0] ks, kd, x32;
	logic [15:0] kps, kpd, x16;
	logic [SET_W-1:0] set_d;
	logic ign_d;

	logic              ign_s1, fwd_s1, tcp_s1, syn_s1, fin_s1;
	logic [63:0]       kaddr_s1, now_s1;
	logic [39:0]       kports_s1;
	logic [15:0]       win_s1, len_s1;
	logic [SET_W-1:0]  set_s1;

	// lookup
	logic found, freeway;
	logic [WAY_W-1:0] hit_way, free_way, way_e;
	rec_t cur, upd;
	logic [1:0] outcome_d;
	logic [31:0] slot_full;

	always_comb begin
		swapped = (src_addr > dst_addr) || ((src_addr == dst_addr) && (src_port > dst_port));
		ks = swapped ? dst_addr : src_addr;
		kd = swapped ? src_addr : dst_addr;
		kps = swapped ? dst_port : src_port;
		kpd = swapped ? src_port : dst_port;
		x32 = ks ^ kd ^ {kps, kpd} ^ {24'd0, ip_protocol};
		x16 = x32[15:0] ^ x32[31:16];
		set_d = SET_W'({16'd0, x16} % FLOW_SETS);
		ign_d = (ether_type != ETH_IPV4) || !headers_complete
			|| ((ip_protocol != PROTO_TCP) && (ip_protocol != PROTO_UDP));
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ign_s1 <= ign_d;
			fwd_s1 <= !swapped;
			tcp_s1 <= (ip_protocol == PROTO_TCP);
			syn_s1 <= tcp_flag_bits[FLAG_SYN_BIT];
			fin_s1 <= tcp_flag_bits[FLAG_FIN_BIT];
			kaddr_s1 <= {ks, kd};
			kports_s1 <= {kps, kpd, ip_protocol};
			now_s1 <= arrival_time;
			win_s1 <= tcp_window;
			len_s1 <= packet_length;
			set_s1 <= set_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= wr_row;
		end
		if (in_acc) begin
			rd_row_q <= mem[set_d];
		end
	end

	always_comb begin
		found = 1'b0;
		freeway = 1'b0;
		hit_way = '0;
		free_way = '0;
		for (int w = 0; w < FLOW_WAYS; w++) begin
			if (rd_row_q.vld[w]) begin
				if (!found && rd_row_q.rec[w].kaddr == kaddr_s1
						&& rd_row_q.rec[w].kports == kports_s1) begin
					found = 1'b1;
					hit_way = WAY_W'(w);
				end
			end else if (!freeway) begin
				freeway = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		way_e = found ? hit_way : free_way;

		if (found) begin
			cur = rd_row_q.rec[hit_way];
		end else begin
			cur = '0;
			cur.kaddr = kaddr_s1;
			cur.kports = kports_s1;
			cur.first = now_s1;
		end

		upd = cur;
		upd.pkts = cur.pkts + 32'd1;
		upd.bytes = cur.bytes + {16'd0, len_s1};
		if (fwd_s1) begin
			upd.fpkts = cur.fpkts + 32'd1;
			upd.fbytes = cur.fbytes + {16'd0, len_s1};
			if (len_s1 > cur.longest) begin
				upd.longest = len_s1;
			end
			if (tcp_s1 && syn_s1) begin
				upd.win = win_s1;
			end
		end
		if (tcp_s1) begin
			if (syn_s1) begin
				upd.cstate = CS_SYN;
			end else if (cur.cstate == CS_SYN) begin
				upd.cstate = CS_ESTAB;
			end
			if (fin_s1) begin
				upd.cstate = CS_FIN;
			end
		end else begin
			upd.cstate = CS_UDP;
		end

		if (ign_s1) begin
			outcome_d = OUT_IGNORED;
		end else if (found) begin
			outcome_d = OUT_UPDATED;
		end else if (freeway) begin
			outcome_d = OUT_INSERTED;
		end else begin
			outcome_d = OUT_FULL;
		end
		slot_full = 32'(set_s1) * 32'(FLOW_WAYS) + 32'(way_e);
	end

	always_comb begin
		wr_row = rd_row_q;
		wr_row.vld[way_e] = 1'b1;
		wr_row.rec[way_e] = upd;
		mem_waddr = set_s1;
		if (clearing) begin
			wr_row = '0;
			mem_waddr = clr_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == SET_W'(FLOW_SETS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (!out_valid || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		clearing = (state_q == ST_CLEAR);
		in_ready = (state_q == ST_IDLE);
		in_acc = in_ready && in_valid;
		lookup_done = (state_q == ST_LOOKUP) && (!out_valid || out_ready);
		mem_we = clearing || (lookup_done
			&& (outcome_d == OUT_UPDATED || outcome_d == OUT_INSERTED));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + SET_W'(1);
			if (lookup_done) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_done) begin
			outcome <= outcome_d;
			if (outcome_d == OUT_UPDATED || outcome_d == OUT_INSERTED) begin
				slot <= slot_full[SLOT_W-1:0];
				forward_dir <= fwd_s1;
				flow_packets <= upd.pkts;
				flow_bytes <= upd.bytes;
				forward_packets <= upd.fpkts;
				forward_bytes <= upd.fbytes;
				longest_forward <= upd.longest;
				syn_window <= upd.win;
				conn_state <= upd.cstate;
				flow_start <= upd.first;
			end else begin
				slot <= '0;
				forward_dir <= 1'b0;
				flow_packets <= '0;
				flow_bytes <= '0;
				forward_packets <= '0;
				forward_bytes <= '0;
				longest_forward <= '0;
				syn_window <= '0;
				conn_state <= '0;
				flow_start <= '0;
			end
		end
	end

	`BFST_ASSERT_NEXT(a_acc_lookup, in_valid && in_ready, state_q == ST_LOOKUP,
		"accepted request did not enter lookup")
	`BFST_ASSERT_NOW(a_clear_block, state_q == ST_CLEAR, !in_ready && !out_valid,
		"request path active during clearing pass")
	`BFST_ASSERT_NEXT(a_done_out, lookup_done, out_valid,
		"finished lookup did not raise out_valid")

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Flow statistics table testbench
// Drives frame header requests with bursty valid and a stalling receiver.
// A behavioral copy of the flow table predicts every result; each output is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bfst_pkg::*;

	typedef struct {
		logic [15:0] etype;
		logic [7:0]  proto;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  flags;
		logic [15:0] win;
		logic [15:0] len;
		logic [63:0] stamp;
		logic        complete;
	} frame_t;

	typedef struct {
		logic [1:0]  outcome;
		logic [9:0]  slot;
		logic        fwd;
		logic [31:0] pkts;
		logic [31:0] bytes;
		logic [31:0] fpkts;
		logic [31:0] fbytes;
		logic [15:0] longest;
		logic [15:0] win;
		logic [1:0]  cstate;
		logic [63:0] start;
	} flow_result_t;

	localparam int ENTRIES = FLOW_SETS * FLOW_WAYS;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [15:0] ether_type = 0;
	logic [7:0]  ip_protocol = 0;
	logic [31:0] src_addr = 0;
	logic [31:0] dst_addr = 0;
	logic [15:0] src_port = 0;
	logic [15:0] dst_port = 0;
	logic [7:0]  tcp_flag_bits = 0;
	logic [15:0] tcp_window = 0;
	logic [15:0] packet_length = 0;
	logic [63:0] arrival_time = 0;
	logic        headers_complete = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0]  outcome;
	logic [9:0]  slot;
	logic        forward_dir;
	logic [31:0] flow_packets, flow_bytes, forward_packets, forward_bytes;
	logic [15:0] longest_forward, syn_window;
	logic [1:0]  conn_state;
	logic [63:0] flow_start;

	bidirectional_flow_stats_table_core uut (.*);

	// flow table shadow
	bit          t_vld[ENTRIES];
	logic [63:0] t_kaddr[ENTRIES];
	logic [39:0] t_kports[ENTRIES];
	logic [63:0] t_first[ENTRIES];
	logic [31:0] t_pkts[ENTRIES], t_bytes[ENTRIES], t_fpkts[ENTRIES], t_fbytes[ENTRIES];
	logic [15:0] t_longest[ENTRIES], t_win[ENTRIES];
	logic [1:0]  t_cs[ENTRIES];

	frame_t       pending_frames[$];
	flow_result_t expected_results[$];
	frame_t       f_cur;
	int errors = 0;
	bit all_sent = 0;
	bit long_hold = 0;
	bit sender_pause = 0;
	int burst_left = 0, gap_left = 0;
	int stall_left = 0;

	initial forever #5 clk = ~clk;

	initial begin
		#10ms;
		$display("bidirectional_flow_stats_table_core: mismatch");
		$finish;
	end

	function automatic flow_result_t update_flow(frame_t f);
		flow_result_t r;
		bit swapped, tcp, found, freeway;
		logic [31:0] ks, kd, x;
		logic [15:0] kps, kpd;
		logic [63:0] kaddr;
		logic [39:0] kports;
		int set, e, i;
		r = '{default: 0};
		if (f.etype != ETH_IPV4 || !f.complete || (f.proto != PROTO_TCP && f.proto != PROTO_UDP))
			return r;
		tcp = f.proto == PROTO_TCP;
		swapped = f.saddr > f.daddr || (f.saddr == f.daddr && f.sport > f.dport);
		ks = swapped ? f.daddr : f.saddr;
		kd = swapped ? f.saddr : f.daddr;
		kps = swapped ? f.dport : f.sport;
		kpd = swapped ? f.sport : f.dport;
		kaddr = {ks, kd};
		kports = {kps, kpd, f.proto};
		x = ks ^ kd ^ {kps, kpd} ^ {24'd0, f.proto};
		x = x ^ (x >> 16);
		set = int'(x[15:0]) % FLOW_SETS;
		found = 0;
		freeway = 0;
		e = 0;
		for (int w = 0; w < FLOW_WAYS; w++) begin
			i = set * FLOW_WAYS + w;
			if (t_vld[i]) begin
				if (!found && t_kaddr[i] == kaddr && t_kports[i] == kports) begin
					found = 1;
					e = i;
				end
			end else if (!found && !freeway) begin
				freeway = 1;
				e = i;
			end
		end
		if (found) begin
			r.outcome = OUT_UPDATED;
		end else if (freeway) begin
			r.outcome = OUT_INSERTED;
			t_vld[e] = 1;
			t_kaddr[e] = kaddr;
			t_kports[e] = kports;
			t_first[e] = f.stamp;
			t_pkts[e] = 0;
			t_bytes[e] = 0;
			t_fpkts[e] = 0;
			t_fbytes[e] = 0;
			t_longest[e] = 0;
			t_win[e] = 0;
			t_cs[e] = CS_SYN;
		end else begin
			r.outcome = OUT_FULL;
			return r;
		end
		t_pkts[e] += 1;
		t_bytes[e] += f.len;
		if (!swapped) begin
			t_fpkts[e] += 1;
			t_fbytes[e] += f.len;
			if (f.len > t_longest[e])
				t_longest[e] = f.len;
			if (tcp && f.flags[FLAG_SYN_BIT])
				t_win[e] = f.win;
		end
		if (tcp) begin
			if (f.flags[FLAG_SYN_BIT])
				t_cs[e] = CS_SYN;
			else if (t_cs[e] == CS_SYN)
				t_cs[e] = CS_ESTAB;
			if (f.flags[FLAG_FIN_BIT])
				t_cs[e] = CS_FIN;
		end else begin
			t_cs[e] = CS_UDP;
		end
		r.slot = e[9:0];
		r.fwd = !swapped;
		r.pkts = t_pkts[e];
		r.bytes = t_bytes[e];
		r.fpkts = t_fpkts[e];
		r.fbytes = t_fbytes[e];
		r.longest = t_longest[e];
		r.win = t_win[e];
		r.cstate = t_cs[e];
		r.start = t_first[e];
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("%0t: %s got %0h want %0h", $realtime, what, got, want);
	endtask

	// driver
	always @(posedge clk) begin
		frame_t f;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				void'(pending_frames.pop_front());
				expected_results.push_back(update_flow(f_cur));
			end
			if (in_valid && !in_ready) begin
				// hold
			end else if (pending_frames.size() > 0 && !sender_pause && (burst_left > 0)) begin
				f = pending_frames[0];
				in_valid <= 1;
				ether_type <= f.etype;
				ip_protocol <= f.proto;
				src_addr <= f.saddr;
				dst_addr <= f.daddr;
				src_port <= f.sport;
				dst_port <= f.dport;
				tcp_flag_bits <= f.flags;
				tcp_window <= f.win;
				packet_length <= f.len;
				arrival_time <= f.stamp;
				headers_complete <= f.complete;
				f_cur <= f;
				burst_left <= burst_left - 1;
			end else begin
				in_valid <= 0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				else begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold)
				out_ready <= 0;
			else if (stall_left > 0) begin
				out_ready <= 0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1;
				if ($urandom_range(0, 9) == 0)
					stall_left <= ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3)
						: $urandom_range(4, 20);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		flow_result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report("unexpected result outcome", outcome, 0);
			end else begin
				w = expected_results.pop_front();
				if (outcome !== w.outcome) report("outcome", outcome, w.outcome);
				if (slot !== w.slot) report("slot", slot, w.slot);
				if (forward_dir !== w.fwd) report("forward_dir", forward_dir, w.fwd);
				if (flow_packets !== w.pkts) report("flow_packets", flow_packets, w.pkts);
				if (flow_bytes !== w.bytes) report("flow_bytes", flow_bytes, w.bytes);
				if (forward_packets !== w.fpkts)
					report("forward_packets", forward_packets, w.fpkts);
				if (forward_bytes !== w.fbytes)
					report("forward_bytes", forward_bytes, w.fbytes);
				if (longest_forward !== w.longest)
					report("longest_forward", longest_forward, w.longest);
				if (syn_window !== w.win) report("syn_window", syn_window, w.win);
				if (conn_state !== w.cstate) report("conn_state", conn_state, w.cstate);
				if (flow_start !== w.start) report("flow_start", flow_start, w.start);
			end
		end
	end

	function automatic frame_t noise_frame();
		frame_t f;
		f.etype = $urandom;
		f.proto = $urandom;
		f.saddr = $urandom;
		f.daddr = $urandom;
		f.sport = $urandom;
		f.dport = $urandom;
		f.flags = $urandom;
		f.win = $urandom;
		f.len = $urandom;
		f.stamp = {$urandom, $urandom};
		f.complete = $urandom;
		return f;
	endfunction

	function automatic frame_t flow_frame(logic [31:0] a, logic [31:0] b, logic [15:0] pa,
		logic [15:0] pb, logic [7:0] proto);
		frame_t f;
		f = noise_frame();
		f.etype = ETH_IPV4;
		f.complete = 1;
		f.proto = proto;
		if ($urandom_range(0, 1)) begin
			f.saddr = a; f.daddr = b; f.sport = pa; f.dport = pb;
		end else begin
			f.saddr = b; f.daddr = a; f.sport = pb; f.dport = pa;
		end
		f.flags = $urandom_range(0, 3) == 0 ? 8'h02 : ($urandom_range(0, 5) == 0 ? 8'h01
			: $urandom);
		return f;
	endfunction

	task automatic add(frame_t f);
		pending_frames.push_back(f);
	endtask

	initial begin
		frame_t f;
		logic [31:0] fa[32], fb[32];
		logic [15:0] pa[32], pb[32];
		logic [7:0]  pr[32];
		int k, cnt;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed
		f = flow_frame(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, PROTO_TCP);
		f.saddr = 0; f.daddr = 32'hFFFF_FFFF; f.sport = 0; f.dport = 16'hFFFF;
		f.flags = 8'h02; f.stamp = 0; f.len = 16'hFFFF; f.win = 16'hFFFF;
		add(f);
		f.flags = 8'h00; f.len = 0; add(f);
		f.saddr = 32'hFFFF_FFFF; f.daddr = 0; f.sport = 16'hFFFF; f.dport = 0;
		f.flags = 8'h01; f.stamp = '1; add(f);
		f.flags = 8'hFF; add(f);
		f.saddr = 32'h0A00_0001; f.daddr = 32'h0A00_0001; f.sport = 80; f.dport = 80;
		f.proto = PROTO_UDP; add(f);
		f.sport = 90; f.dport = 80; add(f);
		f.sport = 70; add(f);
		f = noise_frame(); f.etype = 16'h86DD; add(f);
		f.etype = ETH_IPV4; f.complete = 0; f.proto = PROTO_TCP; add(f);
		f.complete = 1; f.proto = 8'd1; add(f);
		f.proto = 8'hFF; add(f);
		// several short flows with shifted addresses and fixed ports
		for (int j = 0; j < FLOW_WAYS + 2; j++) begin
			f = flow_frame(32'h0101_0101 + (j << 16), 32'h0202_0202 + (j << 16),
				16'd1000, 16'd2000, PROTO_TCP);
			add(f);
		end

		// flows
		for (int j = 0; j < 32; j++) begin
			fa[j] = $urandom; fb[j] = ($urandom_range(0, 7) == 0) ? fa[j] : $urandom;
			pa[j] = $urandom; pb[j] = $urandom;
			pr[j] = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
		end
		// make several flows collide into one set to reach table full
		for (int j = 0; j < 6; j++) begin
			fa[j] = 32'h1000_0000 + j * 32'h0001_0001;
			fb[j] = 32'h2000_0000;
			pa[j] = 16'h0; pb[j] = 16'h0;
			pr[j] = PROTO_UDP;
		end
		cnt = 0;
		while (cnt < 1750) begin
			if (cnt == 600) begin
				wait (pending_frames.size() == 0 && !in_valid);
				sender_pause = 1;
				wait (expected_results.size() == 0);
				repeat (4) @(posedge clk);
				sender_pause = 0;
			end
			if (cnt == 900) begin
				long_hold = 1;
			end
			k = $urandom_range(0, 31);
			if ($urandom_range(0, 9) < 8)
				add(flow_frame(fa[k], fb[k], pa[k], pb[k], pr[k]));
			else
				add(noise_frame());
			cnt++;
			if (cnt % 20 == 0)
				wait (pending_frames.size() < 40);
		end
		all_sent = 1;
	end

	// long receiver hold, counted in cycles
	initial begin
		wait (long_hold);
		repeat (300) @(posedge clk);
		long_hold = 0;
	end

	initial begin
		wait (all_sent && pending_frames.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("bidirectional_flow_stats_table_core: match");
		else
			$display("bidirectional_flow_stats_table_core: mismatch");
		$finish;
	end
endmodule
